### rtl/gtu_pkg.sv
// gtu_pkg: field widths, calendar constants and a small lookup function
// shared by the gps-to-utc calendar interfaces and pipeline
// no dependencies
`timescale 1ns / 1ps

package gtu_pkg;

    // input field widths
    localparam int WS_W   = 20;
    localparam int LS_W   = 8;
    localparam int WSD_W  = 17;

    // output field widths
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;

    // internal widths
    localparam int T_W    = 20;  // non-negative seconds before day split
    localparam int Q_W    = 4;   // whole days in the seconds, 0..12
    localparam int TOD_W  = 17;  // time of day, 0..86399
    localparam int REM1_W = 12;  // seconds within the hour
    localparam int JD_W   = 22;  // julian day number
    localparam int X_W    = 24;  // 4*jd minus century offset
    localparam int W_W    = 5;   // gregorian century correction, 15..19
    localparam int NUM_W  = 26;  // 20*b - 2442
    localparam int PROD_W = 40;  // num times reciprocal
    localparam int C_W    = 13;  // julian year count
    localparam int REM_W  = 15;  // remainder before correction, below 2*7305
    localparam int BD_W   = 10;  // day of shifted year, b - d
    localparam int P_W    = 24;  // 10000*(b - d)
    localparam int E_W    = 4;   // shifted month, 4..15
    localparam int F_W    = 9;   // days before the shifted month

    // calendar constants
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int JD_OF_EPOCH   = 2447892;
    localparam int CENT_OFFSET   = 7468865;
    localparam int CENT_DAYS     = 146097;
    localparam int W_MIN         = 15;
    localparam int W_MAX         = 19;
    localparam int B_OFFSET      = 1525;   // the +1 and the +1524 together
    localparam int YEAR_NUM_OFF  = 2442;
    localparam int YEAR_DIV      = 7305;
    localparam int DAYS_PER_4Y   = 1461;
    localparam int MONTH_SCALE   = 10000;
    localparam int MONTH_DIV     = 306001;
    localparam int E_MAX         = 15;
    localparam int YEAR_BASE     = 4716;
    localparam int MONTHS        = 12;

    // reciprocal of 7305, floor(2^26 / 7305); estimate is low by at most one
    localparam int RECIP_SHIFT = NUM_W;
    localparam longint RECIP_C = (64'd1 << RECIP_SHIFT) / YEAR_DIV;

    // ceil(2^17 / 60): exact quotient for every value below 3600
    localparam int MIN_SHIFT = 17;
    localparam int MIN_RECIP = ((1 << MIN_SHIFT) + SECS_PER_MIN - 1) / SECS_PER_MIN;
    localparam int MIN_PROD_W = REM1_W + 12;

    // floor(30.6001 * e): days that precede shifted month e
    function automatic logic [F_W-1:0] month_start(input logic [E_W-1:0] e);
        logic [F_W-1:0] f;
        begin
            case (e)
                4'd0:    f = 9'd0;
                4'd1:    f = 9'd30;
                4'd2:    f = 9'd61;
                4'd3:    f = 9'd91;
                4'd4:    f = 9'd122;
                4'd5:    f = 9'd153;
                4'd6:    f = 9'd183;
                4'd7:    f = 9'd214;
                4'd8:    f = 9'd244;
                4'd9:    f = 9'd275;
                4'd10:   f = 9'd306;
                4'd11:   f = 9'd336;
                4'd12:   f = 9'd367;
                4'd13:   f = 9'd397;
                4'd14:   f = 9'd428;
                4'd15:   f = 9'd459;
                default: f = 9'd0;
            endcase
            return f;
        end
    endfunction

endpackage

### rtl/gtu_if.sv
// gtu_time_if and gtu_date_if: valid/ready channels for the time record
// going in and the calendar record coming out
// depends on gtu_pkg
`timescale 1ns / 1ps

interface gtu_time_if;
    logic                          valid;
    logic                          ready;
    logic [gtu_pkg::WS_W-1:0]      week_seconds;
    logic [gtu_pkg::LS_W-1:0]      leap_seconds;
    logic [gtu_pkg::WSD_W-1:0]     week_start_days;

    modport source (output valid, week_seconds, leap_seconds, week_start_days,
                    input  ready);
    modport sink   (input  valid, week_seconds, leap_seconds, week_start_days,
                    output ready);
endinterface

interface gtu_date_if;
    logic                          valid;
    logic                          ready;
    logic [gtu_pkg::HOUR_W-1:0]    hour;
    logic [gtu_pkg::MIN_W-1:0]     minute;
    logic [gtu_pkg::SEC_W-1:0]     second;
    logic [gtu_pkg::DAY_W-1:0]     day;
    logic [gtu_pkg::MONTH_W-1:0]   month;
    logic [gtu_pkg::YEAR_W-1:0]    year;

    modport source (output valid, hour, minute, second, day, month, year,
                    input  ready);
    modport sink   (input  valid, hour, minute, second, day, month, year,
                    output ready);
endinterface

### rtl/gps_time_to_utc_calendar_unit.sv
// gps_time_to_utc_calendar_unit: eleven-stage pipeline turning gps week time
// into utc time of day and gregorian date (julian day, meeus method)
// depends on gtu_pkg, gtu_time_if, gtu_date_if
//
//  channel   dir  modport  fields
//  i_time    in   sink     week_seconds, leap_seconds, week_start_days
//  o_date    out  source   hour, minute, second, day, month, year
//
// one transaction enters per cycle unless the pipeline is full and the output stalled;
// its result leaves through the output register of the eleven register stages
// the pipeline depth is set by the chain of constant divisions for the year
// (reciprocal multiply, then remainder correction, then month search)
// each stage holds while the one after it is full and stalled, and
// refills as soon as it moves on, so bubbles are squeezed out
// reset clears the stage valid bits only
`timescale 1ns / 1ps

module gps_time_to_utc_calendar_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gtu_time_if.sink   i_time,
    gtu_date_if.source o_date
);

    localparam int NSTG = 11;

    logic [NSTG:1] r_vld;
    logic [NSTG:1] stg_en;

    // ---------------- stage 1: leap correction and borrow
    logic [gtu_pkg::T_W:0]      n_s1_raw;
    logic                       n_s1_neg;
    logic [gtu_pkg::T_W-1:0]    n_s1_t;
    logic [gtu_pkg::JD_W-1:0]   n_s1_jd0;
    logic [gtu_pkg::T_W-1:0]    r_s1_t;
    logic [gtu_pkg::JD_W-1:0]   r_s1_jd0;

    always_comb begin
        n_s1_raw = {1'b0, i_time.week_seconds}
                 - (gtu_pkg::T_W + 1)'(i_time.leap_seconds);
        n_s1_neg = n_s1_raw[gtu_pkg::T_W];
        // negative time borrows a day
        n_s1_t   = n_s1_neg
                 ? gtu_pkg::T_W'(n_s1_raw + (gtu_pkg::T_W + 1)'(gtu_pkg::SECS_PER_DAY))
                 : n_s1_raw[gtu_pkg::T_W-1:0];
        n_s1_jd0 = gtu_pkg::JD_W'(i_time.week_start_days)
                 + gtu_pkg::JD_W'(gtu_pkg::JD_OF_EPOCH)
                 - gtu_pkg::JD_W'(n_s1_neg);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_s1_t   <= n_s1_t;
            r_s1_jd0 <= n_s1_jd0;
        end
    end

    // ---------------- stage 2: whole days in the seconds
    logic [gtu_pkg::Q_W-1:0]    n_s2_q;
    logic [gtu_pkg::T_W-1:0]    r_s2_t;
    logic [gtu_pkg::Q_W-1:0]    r_s2_q;
    logic [gtu_pkg::JD_W-1:0]   r_s2_jd0;

    always_comb begin
        n_s2_q = '0;
        for (int k = 1; k <= 12; k++) begin
            if (r_s1_t >= gtu_pkg::T_W'(k * gtu_pkg::SECS_PER_DAY)) begin
                n_s2_q = gtu_pkg::Q_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_s2_t   <= r_s1_t;
            r_s2_q   <= n_s2_q;
            r_s2_jd0 <= r_s1_jd0;
        end
    end

    // ---------------- stage 3: time of day and julian day
    logic [gtu_pkg::TOD_W-1:0]  n_s3_tod;
    logic [gtu_pkg::JD_W-1:0]   n_s3_jd;
    logic [gtu_pkg::TOD_W-1:0]  r_s3_tod;
    logic [gtu_pkg::JD_W-1:0]   r_s3_jd;

    always_comb begin
        n_s3_tod = gtu_pkg::TOD_W'(r_s2_t
                 - gtu_pkg::T_W'(int'(r_s2_q) * gtu_pkg::SECS_PER_DAY));
        n_s3_jd  = r_s2_jd0 + gtu_pkg::JD_W'(r_s2_q);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_s3_tod <= n_s3_tod;
            r_s3_jd  <= n_s3_jd;
        end
    end

    // ---------------- stage 4: century correction and hour
    logic [gtu_pkg::X_W-1:0]    n_s4_x;
    logic [gtu_pkg::W_W-1:0]    n_s4_w;
    logic [gtu_pkg::HOUR_W-1:0] n_s4_hour;
    logic [gtu_pkg::JD_W-1:0]   r_s4_jd;
    logic [gtu_pkg::W_W-1:0]    r_s4_w;
    logic [gtu_pkg::TOD_W-1:0]  r_s4_tod;
    logic [gtu_pkg::HOUR_W-1:0] r_s4_hour;

    always_comb begin
        n_s4_x = {r_s3_jd, 2'b00} - gtu_pkg::X_W'(gtu_pkg::CENT_OFFSET);
        // quotient is always between 15 and 19 for any julian day reachable here
        n_s4_w = gtu_pkg::W_W'(gtu_pkg::W_MIN);
        for (int k = gtu_pkg::W_MIN + 1; k <= gtu_pkg::W_MAX; k++) begin
            if (n_s4_x >= gtu_pkg::X_W'(k * gtu_pkg::CENT_DAYS)) begin
                n_s4_w = gtu_pkg::W_W'(k);
            end
        end
        n_s4_hour = '0;
        for (int k = 1; k <= 23; k++) begin
            if (r_s3_tod >= gtu_pkg::TOD_W'(k * gtu_pkg::SECS_PER_HOUR)) begin
                n_s4_hour = gtu_pkg::HOUR_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_s4_jd   <= r_s3_jd;
            r_s4_w    <= n_s4_w;
            r_s4_tod  <= r_s3_tod;
            r_s4_hour <= n_s4_hour;
        end
    end

    // ---------------- stage 5: b and seconds within the hour
    logic [gtu_pkg::JD_W-1:0]   n_s5_b;
    logic [gtu_pkg::REM1_W-1:0] n_s5_rem1;
    logic [gtu_pkg::JD_W-1:0]   r_s5_b;
    logic [gtu_pkg::REM1_W-1:0] r_s5_rem1;
    logic [gtu_pkg::HOUR_W-1:0] r_s5_hour;

    always_comb begin
        n_s5_b    = r_s4_jd + gtu_pkg::JD_W'(r_s4_w)
                  + gtu_pkg::JD_W'(gtu_pkg::B_OFFSET)
                  - gtu_pkg::JD_W'(r_s4_w >> 2);
        n_s5_rem1 = gtu_pkg::REM1_W'(r_s4_tod
                  - gtu_pkg::TOD_W'(int'(r_s4_hour) * gtu_pkg::SECS_PER_HOUR));
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r_s5_b    <= n_s5_b;
            r_s5_rem1 <= n_s5_rem1;
            r_s5_hour <= r_s4_hour;
        end
    end

    // ---------------- stage 6: year numerator and minute
    logic [gtu_pkg::NUM_W-1:0]      n_s6_num;
    logic [gtu_pkg::MIN_PROD_W-1:0] n_s6_mprod;
    logic [gtu_pkg::NUM_W-1:0]      r_s6_num;
    logic [gtu_pkg::JD_W-1:0]       r_s6_b;
    logic [gtu_pkg::REM1_W-1:0]     r_s6_rem1;
    logic [gtu_pkg::HOUR_W-1:0]     r_s6_hour;
    logic [gtu_pkg::MIN_W-1:0]      r_s6_minute;

    always_comb begin
        n_s6_num   = gtu_pkg::NUM_W'(r_s5_b) * gtu_pkg::NUM_W'(20)
                   - gtu_pkg::NUM_W'(gtu_pkg::YEAR_NUM_OFF);
        n_s6_mprod = gtu_pkg::MIN_PROD_W'(r_s5_rem1)
                   * gtu_pkg::MIN_PROD_W'(gtu_pkg::MIN_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            r_s6_num    <= n_s6_num;
            r_s6_b      <= r_s5_b;
            r_s6_rem1   <= r_s5_rem1;
            r_s6_hour   <= r_s5_hour;
            r_s6_minute <= gtu_pkg::MIN_W'(n_s6_mprod >> gtu_pkg::MIN_SHIFT);
        end
    end

    // ---------------- stage 7: reciprocal product and second
    logic [gtu_pkg::PROD_W-1:0] n_s7_prod;
    logic [gtu_pkg::SEC_W-1:0]  n_s7_second;
    logic [gtu_pkg::PROD_W-1:0] r_s7_prod;
    logic [gtu_pkg::NUM_W-1:0]  r_s7_num;
    logic [gtu_pkg::JD_W-1:0]   r_s7_b;
    logic [gtu_pkg::HOUR_W-1:0] r_s7_hour;
    logic [gtu_pkg::MIN_W-1:0]  r_s7_minute;
    logic [gtu_pkg::SEC_W-1:0]  r_s7_second;

    always_comb begin
        n_s7_prod   = gtu_pkg::PROD_W'(r_s6_num) * gtu_pkg::PROD_W'(gtu_pkg::RECIP_C);
        n_s7_second = gtu_pkg::SEC_W'(r_s6_rem1
                    - gtu_pkg::REM1_W'(r_s6_minute) * gtu_pkg::REM1_W'(gtu_pkg::SECS_PER_MIN));
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[7]) begin
            r_s7_prod   <= n_s7_prod;
            r_s7_num    <= r_s6_num;
            r_s7_b      <= r_s6_b;
            r_s7_hour   <= r_s6_hour;
            r_s7_minute <= r_s6_minute;
            r_s7_second <= n_s7_second;
        end
    end

    // ---------------- stage 8: quotient estimate and remainder
    logic [gtu_pkg::C_W-1:0]    n_s8_qe;
    logic [gtu_pkg::REM_W-1:0]  n_s8_rem;
    logic [gtu_pkg::C_W-1:0]    r_s8_qe;
    logic [gtu_pkg::REM_W-1:0]  r_s8_rem;
    logic [gtu_pkg::JD_W-1:0]   r_s8_b;
    logic [gtu_pkg::HOUR_W-1:0] r_s8_hour;
    logic [gtu_pkg::MIN_W-1:0]  r_s8_minute;
    logic [gtu_pkg::SEC_W-1:0]  r_s8_second;

    always_comb begin
        n_s8_qe  = gtu_pkg::C_W'(r_s7_prod >> gtu_pkg::RECIP_SHIFT);
        n_s8_rem = gtu_pkg::REM_W'(r_s7_num
                 - gtu_pkg::NUM_W'(n_s8_qe) * gtu_pkg::NUM_W'(gtu_pkg::YEAR_DIV));
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[8]) begin
            r_s8_qe     <= n_s8_qe;
            r_s8_rem    <= n_s8_rem;
            r_s8_b      <= r_s7_b;
            r_s8_hour   <= r_s7_hour;
            r_s8_minute <= r_s7_minute;
            r_s8_second <= r_s7_second;
        end
    end

    // ---------------- stage 9: corrected year count and day of shifted year
    logic [gtu_pkg::C_W-1:0]    n_s9_c;
    logic [gtu_pkg::JD_W-1:0]   n_s9_d;
    logic [gtu_pkg::C_W-1:0]    r_s9_c;
    logic [gtu_pkg::BD_W-1:0]   r_s9_bd;
    logic [gtu_pkg::HOUR_W-1:0] r_s9_hour;
    logic [gtu_pkg::MIN_W-1:0]  r_s9_minute;
    logic [gtu_pkg::SEC_W-1:0]  r_s9_second;

    always_comb begin
        // estimate is at most one short
        n_s9_c = r_s8_qe + gtu_pkg::C_W'(r_s8_rem >= gtu_pkg::REM_W'(gtu_pkg::YEAR_DIV));
        // 1461*c needs 24 bits before the shift
        n_s9_d = gtu_pkg::JD_W'((gtu_pkg::X_W'(n_s9_c)
               * gtu_pkg::X_W'(gtu_pkg::DAYS_PER_4Y)) >> 2);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[9]) begin
            r_s9_c      <= n_s9_c;
            r_s9_bd     <= gtu_pkg::BD_W'(r_s8_b - n_s9_d);
            r_s9_hour   <= r_s8_hour;
            r_s9_minute <= r_s8_minute;
            r_s9_second <= r_s8_second;
        end
    end

    // ---------------- stage 10: shifted month
    logic [gtu_pkg::P_W-1:0]    n_s10_p;
    logic [gtu_pkg::E_W-1:0]    n_s10_e;
    logic [gtu_pkg::E_W-1:0]    r_s10_e;
    logic [gtu_pkg::C_W-1:0]    r_s10_c;
    logic [gtu_pkg::BD_W-1:0]   r_s10_bd;
    logic [gtu_pkg::HOUR_W-1:0] r_s10_hour;
    logic [gtu_pkg::MIN_W-1:0]  r_s10_minute;
    logic [gtu_pkg::SEC_W-1:0]  r_s10_second;

    always_comb begin
        n_s10_p = gtu_pkg::P_W'(r_s9_bd) * gtu_pkg::P_W'(gtu_pkg::MONTH_SCALE);
        n_s10_e = '0;
        for (int k = 1; k <= gtu_pkg::E_MAX; k++) begin
            if (n_s10_p >= gtu_pkg::P_W'(k * gtu_pkg::MONTH_DIV)) begin
                n_s10_e = gtu_pkg::E_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[10]) begin
            r_s10_e      <= n_s10_e;
            r_s10_c      <= r_s9_c;
            r_s10_bd     <= r_s9_bd;
            r_s10_hour   <= r_s9_hour;
            r_s10_minute <= r_s9_minute;
            r_s10_second <= r_s9_second;
        end
    end

    // ---------------- stage 11: day, month, year (output register)
    logic [gtu_pkg::MONTH_W-1:0] n_s11_month;
    logic [gtu_pkg::DAY_W-1:0]   n_s11_day;
    logic [gtu_pkg::YEAR_W-1:0]  n_s11_year;
    logic                        n_s11_early;
    logic [gtu_pkg::HOUR_W-1:0]  r_s11_hour;
    logic [gtu_pkg::MIN_W-1:0]   r_s11_minute;
    logic [gtu_pkg::SEC_W-1:0]   r_s11_second;
    logic [gtu_pkg::DAY_W-1:0]   r_s11_day;
    logic [gtu_pkg::MONTH_W-1:0] r_s11_month;
    logic [gtu_pkg::YEAR_W-1:0]  r_s11_year;

    always_comb begin
        n_s11_day   = gtu_pkg::DAY_W'(r_s10_bd
                    - gtu_pkg::BD_W'(gtu_pkg::month_start(r_s10_e)));
        // shifted months past december wrap to january and february of next year
        n_s11_early = (r_s10_e > gtu_pkg::E_W'(gtu_pkg::MONTHS + 1));
        n_s11_month = n_s11_early
                    ? gtu_pkg::MONTH_W'(r_s10_e - gtu_pkg::E_W'(gtu_pkg::MONTHS + 1))
                    : gtu_pkg::MONTH_W'(r_s10_e - gtu_pkg::E_W'(1));
        n_s11_year  = gtu_pkg::YEAR_W'(r_s10_c - gtu_pkg::C_W'(gtu_pkg::YEAR_BASE)
                    + gtu_pkg::C_W'(n_s11_early));
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[11]) begin
            r_s11_hour   <= r_s10_hour;
            r_s11_minute <= r_s10_minute;
            r_s11_second <= r_s10_second;
            r_s11_day    <= n_s11_day;
            r_s11_month  <= n_s11_month;
            r_s11_year   <= n_s11_year;
        end
    end

    // ---------------- flow control
    always_comb begin
        stg_en[NSTG] = !r_vld[NSTG] || o_date.ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[1]) begin
                r_vld[1] <= i_time.valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_time.ready  = stg_en[1];
    assign o_date.valid  = r_vld[NSTG];
    assign o_date.hour   = r_s11_hour;
    assign o_date.minute = r_s11_minute;
    assign o_date.second = r_s11_second;
    assign o_date.day    = r_s11_day;
    assign o_date.month  = r_s11_month;
    assign o_date.year   = r_s11_year;

    // ---------------- assertions
    // input only backs off when the output is full and stalled
    a_no_spurious_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_time.ready |-> (o_date.valid && !o_date.ready))
        else $error("input stalled while output free");

    // reciprocal estimate must be at most one short
    a_year_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[8] |-> (r_s8_rem < gtu_pkg::REM_W'(2 * gtu_pkg::YEAR_DIV)))
        else $error("year quotient estimate off by more than one");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_date.valid |-> (o_date.month >= gtu_pkg::MONTH_W'(1)
                          && o_date.month <= gtu_pkg::MONTH_W'(gtu_pkg::MONTHS)))
        else $error("month out of range");

endmodule

### dv/gps_time_to_utc_calendar_unit_test.sv
// gps_time_to_utc_calendar_unit_test: random and directed check of the gps week
// time to utc calendar pipeline against a behavioral date predictor
// depends on gtu_pkg, gtu_time_if, gtu_date_if and gps_time_to_utc_calendar_unit
`timescale 1ns / 1ps

module gps_time_to_utc_calendar_unit_test;

    localparam int  HALF_PERIOD  = 4;
    localparam int  RESET_CYCLES = 5;
    localparam int  NUM_RANDOM   = 1400;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  IDLE_PCT     = 38;
    localparam int  MAX_REPORTS  = 10;
    localparam int  WEEK_SECS    = 604799;
    localparam int  WSD_MAX      = (1 << gtu_pkg::WSD_W) - 1;
    localparam int  WS_MAX       = (1 << gtu_pkg::WS_W) - 1;
    localparam int  LS_MAX       = (1 << gtu_pkg::LS_W) - 1;
    localparam int  SPD          = gtu_pkg::SECS_PER_DAY;
    localparam longint RUN_LIMIT_NS = 64'd4_000_000;

    typedef struct packed {
        logic [gtu_pkg::HOUR_W-1:0]  hour;
        logic [gtu_pkg::MIN_W-1:0]   minute;
        logic [gtu_pkg::SEC_W-1:0]   second;
        logic [gtu_pkg::DAY_W-1:0]   day;
        logic [gtu_pkg::MONTH_W-1:0] month;
        logic [gtu_pkg::YEAR_W-1:0]  year;
    } t_date;

    class t_calendar_scoreboard;
        t_date expected_dates[$];
        int    mismatches;
        int    failures;

        function new();
            mismatches = 0;
            failures   = 0;
        endfunction

        // gps week time to utc time of day and gregorian date
        function t_date predict_calendar(logic [gtu_pkg::WS_W-1:0] ws,
                                         logic [gtu_pkg::LS_W-1:0] ls,
                                         logic [gtu_pkg::WSD_W-1:0] wsd);
            longint t, days, jd, w, a, b, c, d, e, f, mon, yr;
            t_date  r;
            t    = longint'(ws) - longint'(ls);
            days = 0;
            // negative seconds borrow one day
            if (t < 0) begin
                t    = t + gtu_pkg::SECS_PER_DAY;
                days = -1;
            end
            while (t >= gtu_pkg::SECS_PER_DAY) begin
                t    = t - gtu_pkg::SECS_PER_DAY;
                days = days + 1;
            end
            jd  = longint'(wsd) + gtu_pkg::JD_OF_EPOCH + days;
            w   = (4 * jd - gtu_pkg::CENT_OFFSET) / gtu_pkg::CENT_DAYS;
            a   = jd + 1 + w - w / 4;
            b   = a + 1524;
            c   = (20 * b - gtu_pkg::YEAR_NUM_OFF) / gtu_pkg::YEAR_DIV;
            d   = (gtu_pkg::DAYS_PER_4Y * c) / 4;
            e   = (gtu_pkg::MONTH_SCALE * (b - d)) / gtu_pkg::MONTH_DIV;
            f   = (gtu_pkg::MONTH_DIV * e) / gtu_pkg::MONTH_SCALE;
            mon = e - 1;
            if (mon > gtu_pkg::MONTHS)
                mon = mon - gtu_pkg::MONTHS;
            yr = c - gtu_pkg::YEAR_BASE;
            if (mon == 1 || mon == 2)
                yr = yr + 1;
            r.hour   = gtu_pkg::HOUR_W'(t / gtu_pkg::SECS_PER_HOUR);
            r.minute = gtu_pkg::MIN_W'((t % gtu_pkg::SECS_PER_HOUR) / gtu_pkg::SECS_PER_MIN);
            r.second = gtu_pkg::SEC_W'(t % gtu_pkg::SECS_PER_MIN);
            r.day    = gtu_pkg::DAY_W'(b - d - f);
            r.month  = gtu_pkg::MONTH_W'(mon);
            r.year   = gtu_pkg::YEAR_W'(yr);
            return r;
        endfunction

        function void note_time(logic [gtu_pkg::WS_W-1:0] ws,
                                logic [gtu_pkg::LS_W-1:0] ls,
                                logic [gtu_pkg::WSD_W-1:0] wsd);
            expected_dates.push_back(predict_calendar(ws, ls, wsd));
        endfunction

        function void check_date(t_date got);
            t_date want;
            if (expected_dates.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected date %0d:%0d:%0d %0d/%0d/%0d",
                             got.hour, got.minute, got.second, got.day, got.month, got.year);
                return;
            end
            want = expected_dates.pop_front();
            if (got.hour !== want.hour || got.minute !== want.minute ||
                got.second !== want.second || got.day !== want.day ||
                got.month !== want.month || got.year !== want.year) begin
                failures++;
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("exp %0d:%0d:%0d %0d/%0d/%0d got %0d:%0d:%0d %0d/%0d/%0d",
                             want.hour, want.minute, want.second,
                             want.day, want.month, want.year,
                             got.hour, got.minute, got.second,
                             got.day, got.month, got.year);
            end
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    gtu_time_if time_if ();
    gtu_date_if date_if ();

    gps_time_to_utc_calendar_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_time  (time_if),
        .o_date  (date_if)
    );

    t_calendar_scoreboard sb;
    int send_idle_pct;
    int sink_idle_pct;

    always #HALF_PERIOD i_clk = ~i_clk;

    // result side: check each accepted transaction, stall at random
    always @(posedge i_clk) begin
        if (date_if.valid === 1'b1 && date_if.ready === 1'b1)
            sb.check_date('{date_if.hour, date_if.minute, date_if.second,
                            date_if.day, date_if.month, date_if.year});
        date_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic send_time(int ws, int ls, int wsd);
        while ($urandom_range(99) < send_idle_pct) begin
            time_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        time_if.valid           <= 1'b1;
        time_if.week_seconds    <= gtu_pkg::WS_W'(ws);
        time_if.leap_seconds    <= gtu_pkg::LS_W'(ls);
        time_if.week_start_days <= gtu_pkg::WSD_W'(wsd);
        @(posedge i_clk);
        while (time_if.ready !== 1'b1)
            @(posedge i_clk);
        sb.note_time(gtu_pkg::WS_W'(ws), gtu_pkg::LS_W'(ls), gtu_pkg::WSD_W'(wsd));
    endtask

    task automatic send_random_time();
        int kind, ws, ls, wsd;
        kind = $urandom_range(99);
        ls   = $urandom_range(40);
        wsd  = $urandom_range(WSD_MAX);
        ws   = $urandom_range(WEEK_SECS);
        if (kind >= 55 && kind < 70) begin
            // near a whole day boundary after the leap shift
            ls = $urandom_range(LS_MAX);
            ws = $urandom_range(12) * SPD + ls + $urandom_range(4) - 2;
            if (ws < 0)
                ws = 0;
            if (ws > WS_MAX)
                ws = WS_MAX;
        end else if (kind >= 70 && kind < 80) begin
            // leap count above the week seconds
            ls = $urandom_range(LS_MAX, 1);
            ws = $urandom_range(ls - 1);
        end else if (kind >= 80 && kind < 90) begin
            ws = $urandom_range(WS_MAX);
            ls = $urandom_range(LS_MAX);
        end else if (kind >= 90) begin
            ws  = $urandom_range(WS_MAX);
            ls  = $urandom_range(LS_MAX);
            wsd = ($urandom_range(1) != 0) ? $urandom_range(3) : WSD_MAX - $urandom_range(3);
        end
        send_time(ws, ls, wsd);
    endtask

    initial begin
        sb = new();
        send_idle_pct           = IDLE_PCT;
        sink_idle_pct           = IDLE_PCT;
        i_rst_n                 <= 1'b0;
        time_if.valid           <= 1'b0;
        time_if.week_seconds    <= '0;
        time_if.leap_seconds    <= '0;
        time_if.week_start_days <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, day rollover, borrow, leap and century dates
        send_time(0, 0, 0);
        send_time(0, LS_MAX, 0);
        send_time(17, 18, 0);
        send_time(WEEK_SECS, 0, WSD_MAX);
        send_time(WS_MAX, 0, WSD_MAX);
        send_time(WS_MAX, LS_MAX, 0);
        send_time(SPD, 0, 100);
        send_time(SPD - 1, 0, 100);
        send_time(SPD + 18, 18, 100);
        send_time(SPD + 17, 18, 100);
        send_time(2 * SPD, 0, 100);
        send_time(12 * SPD, 0, 100);
        send_time(0, 1, 1);
        send_time(43200, 37, 3712);      // 2000-02-29
        send_time(0, 0, 3713);           // 2000-03-01
        send_time(0, 0, 3652);           // 1999-12-31, last day of 1999
        send_time(SPD - 1, 0, 3651);
        send_time(0, 0, 40236);          // 2100-02-28, century not a leap year
        send_time(0, 0, 40237);
        send_time(3599, 0, 59);
        send_time(3600, 0, 58);
        send_time(WEEK_SECS, 18, 131064);
        send_time(0, 0, WSD_MAX);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == 300) begin
                // hold off until the pipeline has fully drained
                time_if.valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge i_clk);
            end
            if (i == 700) begin
                send_idle_pct = 0;
                sink_idle_pct = 0;
            end
            if (i == 1000) begin
                send_idle_pct = IDLE_PCT;
                sink_idle_pct = IDLE_PCT;
            end
            send_random_time();
        end
        time_if.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.failures == 0)
            $display("gps_time_to_utc_calendar_unit verification clean");
        else
            $display("gps_time_to_utc_calendar_unit verification failed");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("gps_time_to_utc_calendar_unit verification failed");
        $finish;
    end

endmodule
